>>> sv/ddf_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the decimal digit formatter
package ddf_pkg;

   localparam int MAX_DIGITS   = 10;
   localparam int NUMBER_WIDTH = 32;

   localparam int DIGIT_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int BIT_CNT_W   = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;

   localparam logic [5:0] CHAR_SPACE = 6'd32;
   localparam logic [5:0] CHAR_ZERO  = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   // control broadcast to every bcd cell of the chain
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

endpackage

>>> sv/ddf_bcd_cell.sv
`timescale 1ns / 1ps
// one bcd digit cell of the shift-and-add-3 chain
module ddf_bcd_cell (
   input  logic                   clock,
   input  ddf_pkg::cell_ctrl_type ctrl,
   input  logic                   bit_in,
   output logic [3:0]             digit,
   output logic                   carry_out
);
   import ddf_pkg::*;

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adjusted;

   // add 3 when the digit would pass 9 after doubling
   assign adjusted  = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
   assign carry_out = adjusted[3];

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = 4'd0;
      end else if (ctrl.shift) begin
         digit_in = {adjusted[2:0], bit_in};
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

>>> sv/decimal_digit_formatter.sv
`timescale 1ns / 1ps
// decimal digit formatter: binary to bcd chain and digit beat emitter
// a taken req beat runs the bit-serial pass through the bcd cell chain in ST_CONVERT,
//   then ST_EMIT registers one rsp beat per digit while rsp_stall is low;
//   req_stall holds off a new req beat until the last digit beat is loaded
// a digit count of zero stays in idle with no rsp beat
// reset clears the state machine and the output valid; no other state is kept
module decimal_digit_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_number,
   input  logic [3:0]  req_digit_count,
   input  logic [7:0]  req_start_column,
   input  logic [2:0]  req_page_row,
   input  logic [7:0]  req_font_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_column,
   output logic [2:0]  rsp_row,
   output logic [5:0]  rsp_char_code,
   output logic        rsp_last
);
   import ddf_pkg::*;

   state_type                state_ff, state_in;
   logic [NUMBER_WIDTH-1:0]  num_ff, num_in;
   logic [BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [DIGIT_IDX_W-1:0]   idx_ff, idx_in;
   logic [7:0]               col_ff, col_in;
   logic [6:0]               step_ff, step_in;
   logic [2:0]               row_ff, row_in;
   logic                     shown_ff, shown_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_column_ff, rsp_column_in;
   logic [2:0]               rsp_row_ff, rsp_row_in;
   logic [5:0]               rsp_char_code_ff, rsp_char_code_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctrl_type            cell_ctrl;
   logic [3:0]               digits [MAX_DIGITS];
   logic                     carry [MAX_DIGITS+1];

   logic                     req_take;
   logic                     load;
   logic [3:0]               count_sat;
   logic [3:0]               cur_digit;
   logic                     is_last;
   logic                     blank;

   assign carry[0] = num_ff[NUMBER_WIDTH-1];

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      ddf_bcd_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .bit_in    (carry[i]),
         .digit     (digits[i]),
         .carry_out (carry[i+1])
      );
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign load      = !rsp_valid_ff || !rsp_stall;

   assign count_sat = (req_digit_count > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : req_digit_count;
   assign cur_digit = digits[idx_ff];
   assign is_last   = (idx_ff == '0);
   // leading zeros blank, the rightmost position always shows its digit
   assign blank     = !shown_ff && !is_last && (cur_digit == 4'd0);

   always_comb begin
      state_in         = state_ff;
      num_in           = num_ff;
      bit_cnt_in       = bit_cnt_ff;
      idx_in           = idx_ff;
      col_in           = col_ff;
      step_in          = step_ff;
      row_in           = row_ff;
      shown_in         = shown_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_column_in    = rsp_column_ff;
      rsp_row_in       = rsp_row_ff;
      rsp_char_code_in = rsp_char_code_ff;
      rsp_last_in      = rsp_last_ff;
      cell_ctrl.clear  = 1'b0;
      cell_ctrl.shift  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               num_in          = req_number[NUMBER_WIDTH-1:0];
               bit_cnt_in      = BIT_CNT_W'(NUMBER_WIDTH - 1);
               idx_in          = DIGIT_IDX_W'(count_sat - 4'd1);
               col_in          = req_start_column;
               step_in         = req_font_size[7:1];
               row_in          = req_page_row;
               shown_in        = 1'b0;
               cell_ctrl.clear = 1'b1;
               if (count_sat != 4'd0) begin
                  state_in = ST_CONVERT;
               end
            end
         end
         ST_CONVERT: begin
            cell_ctrl.shift = 1'b1;
            num_in          = num_ff << 1;
            bit_cnt_in      = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in     = 1'b1;
               rsp_column_in    = col_ff;
               rsp_row_in       = row_ff;
               rsp_char_code_in = blank ? CHAR_SPACE : (CHAR_ZERO + {2'b00, cur_digit});
               rsp_last_in      = is_last;
               shown_in         = shown_ff || !blank;
               col_in           = col_ff + {1'b0, step_ff};
               idx_in           = idx_ff - 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff           <= num_in;
      bit_cnt_ff       <= bit_cnt_in;
      idx_ff           <= idx_in;
      col_ff           <= col_in;
      step_ff          <= step_in;
      row_ff           <= row_in;
      shown_ff         <= shown_in;
      rsp_column_ff    <= rsp_column_in;
      rsp_row_ff       <= rsp_row_in;
      rsp_char_code_ff <= rsp_char_code_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_column    = rsp_column_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_char_code = rsp_char_code_ff;
   assign rsp_last      = rsp_last_ff;

   // conversion only hands over after the full bit count
   a_convert_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && $past(state_ff) == ST_CONVERT) |-> $past(bit_cnt_ff) == '0)
      else $error("emit started before conversion finished");

   // loading the last digit ends the item
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && load && is_last) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("last digit did not end the item");

   // the chain never holds a non-decimal digit in a shown beat
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_char_code_ff == CHAR_SPACE ||
                        (rsp_char_code_ff >= CHAR_ZERO && rsp_char_code_ff <= CHAR_ZERO + 6'd9)))
      else $error("char code out of range");

   // the rightmost position is never blanked
   a_last_shown: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_char_code_ff != CHAR_SPACE)
      else $error("last beat blanked");

endmodule
